// ===== rtl/dnsc_pkg.sv =====
package dnsc_pkg;

   // Characters with a meaning of their own in a host name
   localparam logic [7:0] CHAR_DOT    = 8'h2E;
   localparam logic [7:0] CHAR_HYPHEN = 8'h2D;

   // Saturation points of the running counters
   localparam logic [8:0] TOTAL_SAT = 9'd511;
   localparam logic [6:0] LABEL_SAT = 7'd127;

   // Configuration register indexes
   localparam logic CSR_MAX_NAME_LEN  = 1'b0;
   localparam logic CSR_MAX_LABEL_LEN = 1'b1;

   // Widths of the configuration registers
   localparam int NAME_LEN_W  = 8;
   localparam int LABEL_LEN_W = 6;

   // Classification of one incoming character
   typedef struct packed {
      logic is_dot;
      logic is_hyphen;
      logic is_alnum;
   } char_class_type;

endpackage

// ===== rtl/dnsc_char_class.sv =====
module dnsc_char_class
   import dnsc_pkg::*;
(
   input  logic [7:0]     name_byte,
   output char_class_type char_class
);

   // Letters, digits, hyphen and dot are the only characters allowed.
   always_comb begin
      char_class.is_dot    = (name_byte == CHAR_DOT);
      char_class.is_hyphen = (name_byte == CHAR_HYPHEN);
      char_class.is_alnum  = (name_byte inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]});
   end

endmodule

// ===== rtl/dnsc_name_state.sv =====
module dnsc_name_state
   import dnsc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  char_class_type         char_class,
   input  logic                   final_byte,
   input  logic [NAME_LEN_W-1:0]  max_name_len,
   input  logic [LABEL_LEN_W-1:0] max_label_len,
   output logic                   name_ok
);

   logic [8:0] total_count_ff, total_count_in;
   logic [6:0] label_count_ff, label_count_in;
   logic       at_label_start_ff, at_label_start_in;
   logic       last_was_hyphen_ff, last_was_hyphen_in;
   logic       name_failed_ff, name_failed_in;

   logic [8:0] total_next;
   logic [6:0] label_next;
   logic       start_next;
   logic       hyphen_next;
   logic       failed_next;

   always_comb begin
      total_next  = (total_count_ff < TOTAL_SAT) ? total_count_ff + 9'd1 : total_count_ff;
      label_next  = label_count_ff;
      start_next  = at_label_start_ff;
      hyphen_next = last_was_hyphen_ff;
      failed_next = name_failed_ff;

      if (char_class.is_dot) begin
         // A dot closes the label; an empty label or a trailing hyphen fails.
         if ((label_count_ff == 7'd0) || last_was_hyphen_ff) begin
            failed_next = 1'b1;
         end
         label_next  = 7'd0;
         start_next  = 1'b1;
         hyphen_next = 1'b0;
      end else begin
         if (label_count_ff < LABEL_SAT) begin
            label_next = label_count_ff + 7'd1;
         end
         if (label_next > {1'b0, max_label_len}) begin
            failed_next = 1'b1;
         end
         if (char_class.is_hyphen) begin
            if (at_label_start_ff) begin
               failed_next = 1'b1;
            end
            hyphen_next = 1'b1;
         end else if (char_class.is_alnum) begin
            hyphen_next = 1'b0;
         end else begin
            failed_next = 1'b1;
         end
         start_next = 1'b0;
         if (final_byte && hyphen_next) begin
            failed_next = 1'b1;
         end
      end

      if (final_byte && (total_next > {1'b0, max_name_len})) begin
         failed_next = 1'b1;
      end

      name_ok = ~failed_next;

      total_count_in     = total_count_ff;
      label_count_in     = label_count_ff;
      at_label_start_in  = at_label_start_ff;
      last_was_hyphen_in = last_was_hyphen_ff;
      name_failed_in     = name_failed_ff;
      if (step) begin
         if (final_byte) begin
            total_count_in     = 9'd0;
            label_count_in     = 7'd0;
            at_label_start_in  = 1'b1;
            last_was_hyphen_in = 1'b0;
            name_failed_in     = 1'b0;
         end else begin
            total_count_in     = total_next;
            label_count_in     = label_next;
            at_label_start_in  = start_next;
            last_was_hyphen_in = hyphen_next;
            name_failed_in     = failed_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_count_ff     <= 9'd0;
         label_count_ff     <= 7'd0;
         at_label_start_ff  <= 1'b1;
         last_was_hyphen_ff <= 1'b0;
         name_failed_ff     <= 1'b0;
      end else begin
         total_count_ff     <= total_count_in;
         label_count_ff     <= label_count_in;
         at_label_start_ff  <= at_label_start_in;
         last_was_hyphen_ff <= last_was_hyphen_in;
         name_failed_ff     <= name_failed_in;
      end
   end

endmodule

// ===== rtl/domain_name_syntax_checker.sv =====
// Channel   | Ports       | Contents
// ----------+-------------+--------------------------------------------------
// request   | req_t*      | tdata[7:0] = name_byte, tlast = final_byte
// response  | rsp_t*      | tdata[0] = name_ok, tdata[7:1] = zero
// csr       | csr_*       | index 0 = max_name_len, index 1 = max_label_len
//
// One request is taken every cycle while the response side keeps up. The
// verdict for a name is written to the response register when its final
// request moves on from the input register. Synchronous reset clears the
// name state and both valid flags and loads the register defaults. A stalled
// response holds both stages; a request is still taken while the input
// register is empty.
module domain_name_syntax_checker
   import dnsc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   // request channel
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] name_byte
   input  logic       req_tlast,
   // response channel
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [0] name_ok, [7:1] zero padding
   // configuration write port
   input  logic       csr_we,
   input  logic       csr_index,
   input  logic [7:0] csr_wdata
);

   logic [NAME_LEN_W-1:0]  max_name_len_ff, max_name_len_in;
   logic [LABEL_LEN_W-1:0] max_label_len_ff, max_label_len_in;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;
   logic       in_final_ff, in_final_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_ok_ff, rsp_ok_in;

   logic           advance;
   logic           step;
   logic           name_ok;
   char_class_type char_class;

   // The whole pipe moves whenever the response register is free or being
   // emptied in this cycle.
   assign advance    = ~rsp_valid_ff | rsp_tready;
   assign step       = in_valid_ff & advance;
   assign req_tready = ~in_valid_ff | advance;

   // Configuration registers. Writes must arrive only while the block is idle; the block itself does not enforce this.
   always_comb begin
      max_name_len_in  = max_name_len_ff;
      max_label_len_in = max_label_len_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_MAX_NAME_LEN:  max_name_len_in  = csr_wdata;
            CSR_MAX_LABEL_LEN: max_label_len_in = csr_wdata[LABEL_LEN_W-1:0];
            default: ;
         endcase
      end
   end

   // Input register: loaded whenever it is empty or its content moves on.
   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_final_in = in_final_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
         in_byte_in  = req_tdata;
         in_final_in = req_tlast;
      end
   end

   dnsc_char_class u_char_class (
      .name_byte  (in_byte_ff),
      .char_class (char_class)
   );

   dnsc_name_state u_name_state (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .char_class    (char_class),
      .final_byte    (in_final_ff),
      .max_name_len  (max_name_len_ff),
      .max_label_len (max_label_len_ff),
      .name_ok       (name_ok)
   );

   // Response register: a verdict is loaded on the final character of a name.
   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_ok_in    = rsp_ok_ff;
      if (step && in_final_ff) begin
         rsp_valid_in = 1'b1;
         rsp_ok_in    = name_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_name_len_ff  <= 8'd253;
         max_label_len_ff <= 6'd63;
         in_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         max_name_len_ff  <= max_name_len_in;
         max_label_len_ff <= max_label_len_in;
         in_valid_ff      <= in_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff  <= in_byte_in;
      in_final_ff <= in_final_in;
      rsp_ok_ff   <= rsp_ok_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_ok_ff};

   // With no response pending the block must always take a request.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request refused with response register empty");

   // A final character that moves on must produce a response next cycle.
   a_final_gives_response: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && in_final_ff && advance) |=> rsp_tvalid)
      else $error("final character produced no response");

   // A stalled response holds the character waiting in the input register.
   a_input_held_on_stall: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_byte_ff)
                                     && $stable(in_final_ff)))
      else $error("input register changed during a stall");

   // A full, stalled pipe must refuse further requests.
   a_refuse_when_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready && in_valid_ff) |-> !req_tready)
      else $error("request taken while the pipe is full");

endmodule

// ===== sim/tb_domain_name_syntax_checker.sv =====
`timescale 1ns / 100ps

module tb_domain_name_syntax_checker;
   import dnsc_pkg::*;

   // Scoreboard. It keeps its own copy of the running name state and the two
   // length limits, and works out the verdict for every name whose final byte
   // has been taken. Verdicts wait in order until the response side sees them.
   class verdict_board_type;
      bit [7:0] name_limit;
      bit [5:0] label_limit;
      bit [8:0] total_cnt;
      bit [6:0] label_cnt;
      bit       fresh_label;
      bit       prev_hyphen;
      bit       failed;
      bit       verdicts[$];
      int       mismatches;

      function new();
         name_limit  = 8'd253;
         label_limit = 6'd63;
         mismatches  = 0;
         clear_name();
      endfunction

      function void clear_name();
         total_cnt   = '0;
         label_cnt   = '0;
         fresh_label = 1'b1;
         prev_hyphen = 1'b0;
         failed      = 1'b0;
      endfunction

      function void set_limits(bit [7:0] name_len, bit [7:0] label_max);
         name_limit  = name_len;
         label_limit = label_max[5:0];
      endfunction

      function bit is_letter_or_digit(bit [7:0] c);
         return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
                (c >= 8'h61 && c <= 8'h7A);
      endfunction

      function void note_char(bit [7:0] c, bit last);
         if (total_cnt != TOTAL_SAT) total_cnt++;
         if (c == CHAR_DOT) begin
            if (label_cnt == 0 || prev_hyphen) failed = 1'b1;
            label_cnt   = '0;
            fresh_label = 1'b1;
            prev_hyphen = 1'b0;
         end else begin
            if (label_cnt != LABEL_SAT) label_cnt++;
            if (label_cnt > label_limit) failed = 1'b1;
            if (c == CHAR_HYPHEN) begin
               if (fresh_label) failed = 1'b1;
               prev_hyphen = 1'b1;
            end else if (is_letter_or_digit(c)) begin
               prev_hyphen = 1'b0;
            end else begin
               failed = 1'b1;
            end
            fresh_label = 1'b0;
            if (last && prev_hyphen) failed = 1'b1;
         end
         if (last) begin
            if (total_cnt > name_limit) failed = 1'b1;
            verdicts.push_back(!failed);
            clear_name();
         end
      endfunction

      function void check_verdict(bit [7:0] data);
         bit [7:0] want;
         if (verdicts.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: response %0h with no verdict outstanding", data);
            return;
         end
         want = {7'b0, verdicts.pop_front()};
         if (data !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: verdict mismatch, expected %0h got %0h", want, data);
         end
      endfunction

      function int pending();
         return verdicts.size();
      endfunction
   endclass

   // Ways a random name is built. Plain names are well formed apart from what
   // the label and name limits make of them; the others aim to break a rule.
   typedef enum {
      SHAPE_PLAIN,
      SHAPE_NOISE,
      SHAPE_LONG,
      SHAPE_BAD_BYTE,
      SHAPE_LEAD_HYPHEN,
      SHAPE_TRAIL_HYPHEN,
      SHAPE_EMPTY_LABEL,
      SHAPE_LONE_DOT
   } name_shape_type;

   // A generous bound on cycles in which nothing at all is taken: the longest
   // sender gap plus the longest receiver stall plus the pipeline is far less.
   localparam int STALL_LIMIT = 2000;

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;   // [7:0] name_byte
   logic       req_tlast  = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;            // [0] name_ok, [7:1] zero padding
   logic       csr_we     = 1'b0;
   logic       csr_index  = CSR_MAX_NAME_LEN;
   logic [7:0] csr_wdata  = 8'h00;

   verdict_board_type board = new();

   // The limits currently programmed, used to aim the random names at them.
   bit [7:0] cur_name_limit  = 8'd253;
   bit [5:0] cur_label_limit = 6'd63;

   // While set, neither side idles, which gives back-to-back stretches.
   bit steady = 1'b0;

   int       chars_sent = 0;
   bit [7:0] name_buf[$];

   domain_name_syntax_checker DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Offers one character as a request, after an optional idle gap, and holds
   // it until the block takes it. Every call starts and ends on a rising edge,
   // and each edge sees at most one assignment to the valid flag.
   task automatic send_char(input bit [7:0] c, input bit last);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      chars_sent++;
      board.note_char(c, last);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
   endtask

   task automatic send_name_buf();
      for (int i = 0; i < name_buf.size(); i++)
         send_char(name_buf[i], i == name_buf.size() - 1);
   endtask

   function automatic bit [7:0] random_ldh_char();
      int k;
      k = $urandom_range(0, 61);
      if (k < 10) return 8'h30 + 8'(k);
      if (k < 36) return 8'h41 + 8'(k - 10);
      return 8'h61 + 8'(k - 36);
   endfunction

   // Appends one label of the given length to the name buffer. Hyphens only
   // ever fall inside the label, so on its own the label is well formed.
   function automatic void push_label(int len);
      for (int k = 0; k < len; k++) begin
         if (k > 0 && k < len - 1 && $urandom_range(0, 5) == 0)
            name_buf.push_back(CHAR_HYPHEN);
         else
            name_buf.push_back(random_ldh_char());
      end
   endfunction

   function automatic name_shape_type draw_shape();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return SHAPE_NOISE;
      if (r == 1) return SHAPE_LONG;
      if (r == 2) return SHAPE_BAD_BYTE;
      if (r == 3) return SHAPE_LEAD_HYPHEN;
      if (r == 4) return SHAPE_TRAIL_HYPHEN;
      if (r == 5) return SHAPE_EMPTY_LABEL;
      if (r == 6) return SHAPE_LONE_DOT;
      return SHAPE_PLAIN;
   endfunction

   // Builds one name into the buffer and sends it. Most names are sequences of
   // short labels; some sit at or near the label limit or the name limit, and a
   // few are random bytes or break exactly one rule.
   task automatic send_random_name();
      name_shape_type shape;
      int             cap;
      int             len;
      int             labels;
      int             target;
      shape = draw_shape();
      cap   = (cur_label_limit == 0) ? 1 : int'(cur_label_limit);
      name_buf.delete();
      case (shape)
         SHAPE_NOISE: begin
            repeat ($urandom_range(1, 6)) name_buf.push_back(8'($urandom_range(0, 255)));
         end
         SHAPE_LONG: begin
            target = int'(cur_name_limit) + int'($urandom_range(0, 4)) - 2;
            if (target < 1) target = 1;
            while (name_buf.size() < target) begin
               if (name_buf.size() > 0) name_buf.push_back(CHAR_DOT);
               push_label($urandom_range(1, cap));
            end
            while (name_buf.size() > target) void'(name_buf.pop_back());
         end
         SHAPE_LONE_DOT: begin
            name_buf.push_back(CHAR_DOT);
         end
         default: begin
            labels = $urandom_range(1, 4);
            for (int i = 0; i < labels; i++) begin
               if (i > 0) name_buf.push_back(CHAR_DOT);
               if ($urandom_range(0, 9) == 0) begin
                  len = cap + int'($urandom_range(0, 2)) - 1;
                  if (len < 1) len = 1;
               end else begin
                  len = $urandom_range(1, 8);
               end
               push_label(len);
            end
            case (shape)
               SHAPE_BAD_BYTE:
                  name_buf[$urandom_range(0, name_buf.size() - 1)] =
                     8'($urandom_range(0, 255));
               SHAPE_LEAD_HYPHEN:
                  name_buf.push_front(CHAR_HYPHEN);
               SHAPE_TRAIL_HYPHEN:
                  name_buf.push_back(CHAR_HYPHEN);
               SHAPE_EMPTY_LABEL: begin
                  name_buf.push_back(CHAR_DOT);
                  name_buf.push_back(CHAR_DOT);
                  if ($urandom_range(0, 1) == 1) push_label($urandom_range(1, 3));
               end
               default: ;
            endcase
            // A single trailing dot closes the name and is legal.
            if ($urandom_range(0, 4) == 0) name_buf.push_back(CHAR_DOT);
         end
      endcase
      steady = ($urandom_range(0, 5) == 0);
      send_name_buf();
   endtask

   // Waits until every verdict has come back, then lets the pipeline settle
   // so that the block is idle before the limits are changed.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (board.pending() > 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Writes both limit registers on consecutive edges; the write enable stays
   // high across the pair and drops once.
   task automatic program_limits(input bit [7:0] name_len, input bit [7:0] label_max);
      csr_we    <= 1'b1;
      csr_index <= CSR_MAX_NAME_LEN;
      csr_wdata <= name_len;
      @(posedge clock);
      csr_index <= CSR_MAX_LABEL_LEN;
      csr_wdata <= label_max;
      @(posedge clock);
      csr_we <= 1'b0;
      board.set_limits(name_len, label_max);
      cur_name_limit  = name_len;
      cur_label_limit = label_max[5:0];
   endtask

   task automatic random_phase(input int budget);
      int stop_at;
      stop_at = chars_sent + budget;
      while (chars_sent < stop_at) send_random_name();
   endtask

   // Response side: draws a stall before every response, then holds ready high
   // until a verdict is taken and hands it to the scoreboard.
   initial begin : response_sink
      int stall;
      do @(posedge clock); while (reset);
      forever begin
         stall = steady ? 0 : $urandom_range(0, 13);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         board.check_verdict(rsp_tdata);
      end
   end

   // Watchdog: any request, response or register write restarts the count.
   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
            idle = 0;
         else
            idle++;
      end
      $display("tb_domain_name_syntax_checker NOT OK");
      $finish;
   end

   initial begin : stimulus
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed names under the reset limits: the shortest legal name, a
      // hyphen at either edge of a label, a lone dot, a trailing dot, a name
      // ending in two dots, mixed case with digits, and the two extreme bytes.
      send_text("a");
      send_text("-a");
      send_text("a-");
      send_text(".");
      send_text("a.");
      send_text("a..");
      send_text("a.b-c");
      send_text("Zz09");
      send_char(8'h00, 1'b1);
      send_char(8'hFF, 1'b1);
      random_phase(20);
      drain();

      // Both limits at zero: every name fails.
      program_limits(8'd0, 8'd0);
      send_text("a");
      random_phase(15);
      drain();

      // Smallest legal limits: single characters only.
      program_limits(8'd1, 8'd1);
      send_text("b");
      send_text("ab");
      send_text("a.");
      random_phase(20);
      drain();

      // Largest limits. The label register keeps only its low six bits, so an
      // all-ones write lands on the top label length. One label of 130
      // characters drives the label counter into saturation.
      program_limits(8'd255, 8'hFF);
      name_buf.delete();
      repeat (130) name_buf.push_back(random_ldh_char());
      send_name_buf();
      random_phase(20);
      drain();

      // Tight limits, so that both length rules fire often.
      program_limits(8'd16, 8'd4);
      random_phase(25);
      drain();

      // Any legal setting.
      program_limits(8'($urandom_range(1, 255)), 8'($urandom_range(1, 63)));
      random_phase(25);
      drain();

      // Back to the reset values for the last stretch.
      program_limits(8'd253, 8'd63);
      random_phase(15);

      req_tvalid <= 1'b0;
      while (board.pending() > 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (board.mismatches == 0)
         $display("tb_domain_name_syntax_checker OK");
      else
         $display("tb_domain_name_syntax_checker NOT OK");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/dnsc_pkg.sv
rtl/dnsc_char_class.sv
rtl/dnsc_name_state.sv
rtl/domain_name_syntax_checker.sv
sim/tb_domain_name_syntax_checker.sv
